// File: src/period_constrained_encoder_unit_defines.svh
// Assertion macros for the period constrained encoder.
// Checks compile away when SYNTH is defined.
`ifndef PERIOD_CONSTRAINED_ENCODER_UNIT_DEFINES_SVH
`define PERIOD_CONSTRAINED_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define PCEU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pceu: same-cycle check failed");
// Next-cycle implication.
`define PCEU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pceu: next-cycle check failed");
`else
`define PCEU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PCEU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/pceu_pkg.sv
`default_nettype none

package pceu_pkg;

    localparam int unsigned PB_W          = 5;
    localparam int unsigned WL_W          = 6;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned CFG_DATA_W    = 6;
    localparam int unsigned PB_MAX        = 2 ** PB_W;

    localparam int unsigned DATA_BITS_DEF = 32;
    localparam int unsigned MAX_STEPS_DEF = 1024;

    localparam logic [PB_W-1:0] PB_RESET = 5'd14;
    localparam logic [WL_W-1:0] WL_RESET = 6'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_BOUND  = 1'b0,
        CFG_WINDOW_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_EDIT,
        ST_DONE
    } t_state;

    // Result of one window period check.
    typedef struct packed {
        logic            viol;
        logic [PB_W-1:0] period;
    } t_chk_res;

endpackage

`default_nettype wire

// File: src/pceu_in_if.sv
`default_nettype none

interface pceu_in_if #(
    parameter int unsigned W = pceu_pkg::DATA_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data_word;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

`default_nettype wire

// File: src/pceu_out_if.sv
`default_nettype none

interface pceu_out_if #(
    parameter int unsigned W = pceu_pkg::DATA_BITS_DEF
);
    logic         valid;
    logic         ready;
    logic [W:0]   code_word;
    logic         config_or_limit_error;

    modport source (output valid, output code_word, output config_or_limit_error,
                    input ready);
    modport sink   (input valid, input code_word, input config_or_limit_error,
                    output ready);
endinterface

`default_nettype wire

// File: src/pceu_period_check.sv
`default_nettype none

// Finds the smallest period below the bound in one window, if any.
module pceu_period_check #(
    parameter int unsigned TOTAL = pceu_pkg::DATA_BITS_DEF + 1
) (
    input  logic [TOTAL-1:0]           i_window,
    input  logic [pceu_pkg::WL_W-1:0]  i_win_len,
    input  logic [pceu_pkg::PB_W-1:0]  i_period_bound,
    output pceu_pkg::t_chk_res         o_res
);

    always_comb begin
        logic [TOTAL-1:0] lmask;
        logic [TOTAL-1:0] diff;
        for (int k = 0; k < TOTAL; k++) begin
            lmask[k] = (pceu_pkg::WL_W'(k) < i_win_len);
        end
        o_res = '0;
        diff  = '0;
        // scan downward so the smallest matching period wins
        for (int d = pceu_pkg::PB_MAX - 1; d >= 1; d--) begin
            diff = (i_window ^ (i_window >> d)) & (lmask >> d);
            if ((diff == '0) && (pceu_pkg::PB_W'(d) < i_period_bound)) begin
                o_res.viol   = 1'b1;
                o_res.period = pceu_pkg::PB_W'(d);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/period_constrained_encoder_unit.sv
// Period constrained encoder. Each request carries one DATA_BITS-bit data
// word; the block answers with one code word of DATA_BITS+1 bits in which no
// window of window_length bits has a minimal period below period_bound, plus
// an error flag. A 1 is placed above the data, then window positions are
// scanned in passes; a window with a short period has its repeated tail cut
// out, the period marked by a 1 followed by zeros, and the position appended
// at the top in ceil(log2 DATA_BITS) bits plus a 0. Passes repeat until a
// clean pass. The flag is set when window_length differs from
// period_bound + ceil(log2 DATA_BITS) + 1 (the word is then returned with only
// the 1 appended) or when more than MAX_STEPS replacements would be needed.
// Operation: one request at a time; the input is not ready until the result
// has been taken. One shared window period checker is stepped over the
// positions: each position has a window extraction step and a check step, a
// replacement adds an edit step, and a pass that made a replacement ends with
// a restart step; accepting a request and handing out the result are steps of
// their own. With DATA_BITS = 32 and window_length = 20 a pass covers 14
// positions. Configuration is to be written through i_cfg_we / i_cfg_idx /
// i_cfg_wdata only while the block is idle; the block does not enforce this.
`default_nettype none
`include "period_constrained_encoder_unit_defines.svh"

module period_constrained_encoder_unit #(
    parameter int unsigned DATA_BITS = pceu_pkg::DATA_BITS_DEF,
    parameter int unsigned MAX_STEPS = pceu_pkg::MAX_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pceu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pceu_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    pceu_in_if.sink                           i_data_if,
    pceu_out_if.source                        o_code_if
);

    localparam int unsigned TOTAL  = DATA_BITS + 1;
    localparam int unsigned LOGN   = $clog2(DATA_BITS);
    localparam int unsigned CUT    = LOGN + 1;            // bits removed per replacement
    localparam int unsigned BASE   = TOTAL - CUT;         // start of the position tail
    localparam int unsigned POS_W  = $clog2(TOTAL);
    localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
    localparam int unsigned SUM_W  =
        ((POS_W > pceu_pkg::WL_W) ? POS_W : pceu_pkg::WL_W) + 1;

    // Configuration registers
    logic [pceu_pkg::PB_W-1:0] r_pb;
    logic [pceu_pkg::WL_W-1:0] r_wl;

    // Sequencer and datapath registers
    pceu_pkg::t_state     r_state, n_state;
    logic [TOTAL-1:0]     r_word,  n_word;
    logic [TOTAL-1:0]     r_win,   n_win;
    logic [POS_W-1:0]     r_pos,   n_pos;
    logic [pceu_pkg::PB_W-1:0] r_period, n_period;
    logic [STEP_W-1:0]    r_steps, n_steps;
    logic                 r_found, n_found;
    logic                 r_err,   n_err;

    // Decode signals
    logic                 in_acc;
    logic                 cfg_ok;
    logic                 pos_in;
    logic                 step_limit;
    logic [SUM_W-1:0]     ipd;
    logic [SUM_W-1:0]     cut_at;
    logic [TOTAL-1:0]     shifted;
    logic [CUT-1:0]       tail;
    logic [TOTAL-1:0]     edited;
    pceu_pkg::t_chk_res   chk;

    assign in_acc     = i_data_if.valid && i_data_if.ready;
    assign cfg_ok     = (SUM_W'(r_pb) + SUM_W'(CUT)) == SUM_W'(r_wl);
    assign pos_in     = (SUM_W'(r_pos) + SUM_W'(r_wl)) <= SUM_W'(TOTAL);
    assign step_limit = r_steps >= STEP_W'(MAX_STEPS);

    // Shared window period checker
    pceu_period_check #(
        .TOTAL          (TOTAL)
    ) u_check (
        .i_window       (r_win),
        .i_win_len      (r_wl),
        .i_period_bound (r_pb),
        .o_res          (chk)
    );

    // Replacement: keep bits below pos+period, mark the period with a 1 and
    // zeros up to pos+bound, pull the upper bits down by CUT, append the tail.
    assign ipd     = SUM_W'(r_pos) + SUM_W'(r_period);
    assign cut_at  = SUM_W'(r_pos) + SUM_W'(r_pb);
    assign shifted = r_word >> CUT;
    assign tail    = {1'b0, r_pos[LOGN-1:0]};

    always_comb begin
        for (int k = 0; k < TOTAL; k++) begin
            if (k >= BASE) begin
                edited[k] = tail[k - BASE];
            end else if (SUM_W'(k) < ipd) begin
                edited[k] = r_word[k];
            end else if (SUM_W'(k) == ipd) begin
                edited[k] = 1'b1;
            end else if (SUM_W'(k) < cut_at) begin
                edited[k] = 1'b0;
            end else begin
                edited[k] = shifted[k];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pceu_pkg::ST_IDLE: begin
                if (i_data_if.valid) begin
                    n_state = cfg_ok ? pceu_pkg::ST_LOAD : pceu_pkg::ST_DONE;
                end
            end
            pceu_pkg::ST_LOAD: begin
                if (pos_in) begin
                    n_state = pceu_pkg::ST_CHECK;
                end else if (!r_found) begin
                    n_state = pceu_pkg::ST_DONE;
                end
            end
            pceu_pkg::ST_CHECK: begin
                if (!chk.viol) begin
                    n_state = pceu_pkg::ST_LOAD;
                end else if (step_limit) begin
                    n_state = pceu_pkg::ST_DONE;
                end else begin
                    n_state = pceu_pkg::ST_EDIT;
                end
            end
            pceu_pkg::ST_EDIT: begin
                n_state = pceu_pkg::ST_LOAD;
            end
            pceu_pkg::ST_DONE: begin
                if (o_code_if.ready) begin
                    n_state = pceu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pceu_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        i_data_if.ready = (r_state == pceu_pkg::ST_IDLE);
        o_code_if.valid = (r_state == pceu_pkg::ST_DONE);
    end

    assign o_code_if.code_word             = r_word;
    assign o_code_if.config_or_limit_error = r_err;

    // Datapath next values
    always_comb begin
        n_word   = r_word;
        n_win    = r_win;
        n_pos    = r_pos;
        n_period = r_period;
        n_steps  = r_steps;
        n_found  = r_found;
        n_err    = r_err;
        case (r_state)
            pceu_pkg::ST_IDLE: begin
                if (in_acc) begin
                    // append the marker 1 above the data
                    n_word  = {1'b1, i_data_if.data_word};
                    n_pos   = '0;
                    n_steps = '0;
                    n_found = 1'b0;
                    n_err   = !cfg_ok;
                end
            end
            pceu_pkg::ST_LOAD: begin
                if (pos_in) begin
                    n_win = r_word >> r_pos;
                end else if (r_found) begin
                    // restart the scan for another pass
                    n_pos   = '0;
                    n_found = 1'b0;
                end
            end
            pceu_pkg::ST_CHECK: begin
                if (!chk.viol) begin
                    n_pos = r_pos + 1'b1;
                end else if (step_limit) begin
                    n_err = 1'b1;
                end else begin
                    n_period = chk.period;
                end
            end
            pceu_pkg::ST_EDIT: begin
                n_word  = edited;
                n_steps = r_steps + 1'b1;
                n_found = 1'b1;
                n_pos   = r_pos + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb <= pceu_pkg::PB_RESET;
            r_wl <= pceu_pkg::WL_RESET;
        end else if (i_cfg_we) begin
            case (pceu_pkg::t_cfg_idx'(i_cfg_idx))
                pceu_pkg::CFG_PERIOD_BOUND:  r_pb <= i_cfg_wdata[pceu_pkg::PB_W-1:0];
                pceu_pkg::CFG_WINDOW_LENGTH: r_wl <= i_cfg_wdata[pceu_pkg::WL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pceu_pkg::ST_IDLE;
            r_steps <= '0;
            r_found <= 1'b0;
            r_err   <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
            r_found <= n_found;
            r_err   <= n_err;
            r_pos   <= n_pos;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_win    <= n_win;
        r_period <= n_period;
    end

    // Never offer a new request while a result is pending.
    `PCEU_ASSERT_IMPL(a_ready_excl_valid, i_clk, i_rst_n, o_code_if.valid, !i_data_if.ready)
    // Replacement counter stays within the limit.
    `PCEU_ASSERT_IMPL(a_step_bound, i_clk, i_rst_n, 1'b1, r_steps <= STEP_W'(MAX_STEPS))
    // After a replacement the top code bit is a 0.
    `PCEU_ASSERT_NEXT(a_edit_top_zero, i_clk, i_rst_n, r_state == pceu_pkg::ST_EDIT, !r_word[TOTAL-1])
    // An accepted request starts a scan or goes straight to the result.
    `PCEU_ASSERT_NEXT(a_accept_next, i_clk, i_rst_n, in_acc, r_state == pceu_pkg::ST_LOAD || r_state == pceu_pkg::ST_DONE)

endmodule

`default_nettype wire
